FILE: src/mesh_flood_learn_forwarder_defines.svh
// Assertion macros for the forwarder.
`ifndef MESH_FLOOD_LEARN_FORWARDER_DEFINES_SVH
`define MESH_FLOOD_LEARN_FORWARDER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define MFLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define MFLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mflf_pkg.sv
package mflf_pkg;

  localparam int NUM_PORTS = 8;

  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_CONFIRM = 3'd1;
  localparam logic [2:0] KIND_TICK    = 3'd2;
  localparam logic [2:0] KIND_UP      = 3'd3;
  localparam logic [2:0] KIND_DOWN    = 3'd4;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_REPLY   = 3'd1;
  localparam logic [2:0] ACT_UNICAST = 3'd2;
  localparam logic [2:0] ACT_FLOOD   = 3'd3;
  localparam logic [2:0] ACT_DROP    = 3'd4;

  localparam logic [1:0] ROLE_DEST = 2'd1;
  localparam logic [1:0] ROLE_SRC  = 2'd2;

  localparam logic CFG_ROLE     = 1'b0;
  localparam logic CFG_LIFETIME = 1'b1;

  localparam logic [15:0] LIFETIME_RESET = 16'd10;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic        vld;
    logic [2:0]  kind;
    logic [2:0]  port;
    logic [15:0] id;
    logic        tgt;
    logic        hit;      // an earlier cell held this id
    logic [2:0]  hit_src;  // source port of that entry
  } tok_t;

  // Write broadcast into the row (new tracker entry).
  typedef struct packed {
    logic        en;
    logic [15:0] id;
    logic [2:0]  src;
    logic [15:0] age;
  } wr_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  mask;
    logic        is_conf;
    logic [15:0] id;
    logic        tgt;
    logic        full;
  } res_t;

  function automatic logic [7:0] port_bit(input logic [2:0] p);
    logic [7:0] b;
    b = '0;
    if (int'(p) < NUM_PORTS) begin
      b = 8'd1 << p;
    end
    return b;
  endfunction

endpackage

FILE: src/mesh_flood_learn_forwarder.sv
// Channel   Beat moves                                    Handshake
// -------   --------------------------------------------  -------------------
// in        kind, arrival_port, packet_id, target         in_valid/in_ready
// out       action, port_mask, out_is_confirm,            out_valid/out_ready
//           out_packet_id, out_target, tracker_full
// cfg       cfg_index, cfg_data                           cfg_wr_en (no wait)
//
// For every input beat, a search token walks the row of tracker cells one
// cell per cycle; then the decision is made and the new entry written. One
// beat is in flight at a time.
// Reset (synchronous, rst high) clears all tracker valid bits, routes and port
// states and restores the configuration defaults at once; no sweep is needed.
// A result waiting on out_ready does not block the next input beat; a second
// finished result parks in a hold register, and in_ready drops while it does.
`include "mesh_flood_learn_forwarder_defines.svh"

module mesh_flood_learn_forwarder import mflf_pkg::*; #(
  parameter int TRACKER_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [2:0]  arrival_port,
  input  logic [15:0] packet_id,
  input  logic        target,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  port_mask,
  output logic        out_is_confirm,
  output logic [15:0] out_packet_id,
  output logic        out_target,
  output logic        tracker_full
);

  localparam int IDX_W = (TRACKER_DEPTH > 1) ? $clog2(TRACKER_DEPTH) : 1;

  // config registers
  logic [1:0]  fwd_role;
  logic [15:0] entry_lifetime;

  // forwarding state
  logic [7:0]  ports_active;
  logic [1:0]  route_valid;
  logic [2:0]  route_port [2];

  // flow control
  logic        busy;
  logic        hold_vld;
  res_t        out_res;
  res_t        hold_res;
  logic        in_accept;

  // cell row
  tok_t             tok_chain  [TRACKER_DEPTH+1];
  logic             free_chain [TRACKER_DEPTH+1];
  logic [IDX_W-1:0] fidx_chain [TRACKER_DEPTH+1];
  logic [TRACKER_DEPTH-1:0] chain_vld;
  wr_t              wr;
  tok_t             t_last;

  // decision
  res_t        res_calc;
  logic        reached;
  logic [7:0]  arr_bit;

  assign in_ready  = !busy && !hold_vld;
  assign in_accept = in_valid && in_ready;

  // token enters the first cell on the accepting edge
  always_comb begin
    tok_chain[0].vld     = in_accept;
    tok_chain[0].kind    = kind;
    tok_chain[0].port    = arrival_port;
    tok_chain[0].id      = packet_id;
    tok_chain[0].tgt     = target;
    tok_chain[0].hit     = 1'b0;
    tok_chain[0].hit_src = 3'd0;
  end
  assign free_chain[0] = 1'b0;
  assign fidx_chain[0] = '0;

  for (genvar i = 0; i < TRACKER_DEPTH; i++) begin : g_cell
    mflf_cell #(
      .IDX_W  (IDX_W),
      .MY_IDX (IDX_W'(i))
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (tok_chain[i]),
      .free_in      (free_chain[i]),
      .free_idx_in  (fidx_chain[i]),
      .wr           (wr),
      .wr_idx       (fidx_chain[TRACKER_DEPTH]),
      .tok_out      (tok_chain[i+1]),
      .free_out     (free_chain[i+1]),
      .free_idx_out (fidx_chain[i+1])
    );
    assign chain_vld[i] = tok_chain[i+1].vld;
  end

  assign t_last = tok_chain[TRACKER_DEPTH];

  // Decision once the token has seen every entry.
  // hit: id already tracked; free_chain end: some slot is open,
  // fidx_chain end: lowest open slot.
  always_comb begin
    reached = ((fwd_role == ROLE_DEST) && t_last.tgt) ||
              ((fwd_role == ROLE_SRC) && !t_last.tgt);
    arr_bit = port_bit(t_last.port);
    res_calc = '0;
    wr.en  = 1'b0;
    wr.id  = t_last.id;
    wr.src = t_last.port;
    wr.age = entry_lifetime;
    case (t_last.kind)
      KIND_DATA: begin
        res_calc.id  = t_last.id;
        res_calc.tgt = t_last.tgt;
        if (reached) begin
          res_calc.action  = ACT_REPLY;
          res_calc.mask    = arr_bit;
          res_calc.is_conf = 1'b1;
        end else if (t_last.hit) begin
          res_calc.action = ACT_DROP;
        end else begin
          if (route_valid[t_last.tgt]) begin
            res_calc.action = ACT_UNICAST;
            res_calc.mask   = port_bit(route_port[t_last.tgt]);
          end else begin
            res_calc.action = ACT_FLOOD;
            res_calc.mask   = ports_active & ~arr_bit;
          end
          res_calc.full = !free_chain[TRACKER_DEPTH];
          wr.en         = t_last.vld && free_chain[TRACKER_DEPTH];
        end
      end
      KIND_CONFIRM: begin
        res_calc.id  = t_last.id;
        res_calc.tgt = t_last.tgt;
        if (t_last.hit) begin
          // the matching cell already freed itself as the token passed
          res_calc.action  = ACT_UNICAST;
          res_calc.mask    = port_bit(t_last.hit_src);
          res_calc.is_conf = 1'b1;
        end else begin
          res_calc.action = ACT_DROP;
        end
      end
      default: begin
        res_calc = '0;
      end
    endcase
  end

  // control, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      out_valid      <= 1'b0;
      hold_vld       <= 1'b0;
      ports_active   <= '0;
      route_valid    <= '0;
      route_port[0]  <= 3'd0;
      route_port[1]  <= 3'd0;
      fwd_role       <= 2'd0;
      entry_lifetime <= LIFETIME_RESET;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ROLE:     fwd_role       <= cfg_data[1:0];
          CFG_LIFETIME: entry_lifetime <= cfg_data;
          default:      fwd_role       <= fwd_role;
        endcase
      end

      if (in_accept) begin
        busy <= 1'b1;
      end

      if (t_last.vld) begin
        busy <= 1'b0;
        case (t_last.kind)
          KIND_CONFIRM: begin
            if (t_last.hit) begin
              route_valid[t_last.tgt] <= 1'b1;
              route_port[t_last.tgt]  <= t_last.port;
            end
          end
          KIND_UP: begin
            ports_active <= ports_active | arr_bit;
          end
          KIND_DOWN: begin
            if (arr_bit != 8'd0) begin
              ports_active <= ports_active & ~arr_bit;
              if (route_valid[0] && (route_port[0] == t_last.port)) begin
                route_valid[0] <= 1'b0;
              end
              if (route_valid[1] && (route_port[1] == t_last.port)) begin
                route_valid[1] <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase

        if (!out_valid || out_ready) begin
          out_res   <= res_calc;
          out_valid <= 1'b1;
        end else begin
          hold_res <= res_calc;
          hold_vld <= 1'b1;
        end
      end else if (out_valid && out_ready) begin
        if (hold_vld) begin
          out_res  <= hold_res;
          hold_vld <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign action         = out_res.action;
  assign port_mask      = out_res.mask;
  assign out_is_confirm = out_res.is_conf;
  assign out_packet_id  = out_res.id;
  assign out_target     = out_res.tgt;
  assign tracker_full   = out_res.full;

  // at most one token in the row
  `MFLF_ASSERT_NOW(a_one_token, 1'b1, $countones(chain_vld) <= 1, "two tokens in row")
  // a token leaves the row only for a beat in flight
  `MFLF_ASSERT_NOW(a_tok_busy, t_last.vld, busy, "token without beat in flight")
  // parked result only behind a waiting one
  `MFLF_ASSERT_NOW(a_hold_out, hold_vld, out_valid, "hold full while output empty")
  // one beat at a time
  `MFLF_ASSERT_NEXT(a_accept_block, in_accept, !in_ready, "ready right after accept")

endmodule

FILE: src/mflf_cell.sv
module mflf_cell import mflf_pkg::*; #(
  parameter int               IDX_W  = 4,
  parameter logic [IDX_W-1:0] MY_IDX = '0
) (
  input  logic             clk,
  input  logic             rst,
  input  tok_t             tok_in,
  input  logic             free_in,
  input  logic [IDX_W-1:0] free_idx_in,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] wr_idx,
  output tok_t             tok_out,
  output logic             free_out,
  output logic [IDX_W-1:0] free_idx_out
);

  logic        valid;
  logic [15:0] id;
  logic [2:0]  src;
  logic [15:0] age;
  logic        match;

  assign match = valid && (id == tok_in.id);

  // entry valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (wr_idx == MY_IDX)) begin
      valid <= 1'b1;
    end else if (tok_in.vld) begin
      if ((tok_in.kind == KIND_CONFIRM) && match && !tok_in.hit) begin
        valid <= 1'b0;
      end else if ((tok_in.kind == KIND_TICK) && valid && (age <= 16'd1)) begin
        valid <= 1'b0;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == MY_IDX)) begin
      id  <= wr.id;
      src <= wr.src;
      age <= wr.age;
    end else if (tok_in.vld && (tok_in.kind == KIND_TICK) && valid) begin
      age <= (age <= 16'd1) ? 16'd0 : age - 16'd1;
    end
  end

  // token hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.kind    <= tok_in.kind;
    tok_out.port    <= tok_in.port;
    tok_out.id      <= tok_in.id;
    tok_out.tgt     <= tok_in.tgt;
    tok_out.hit     <= tok_in.hit || match;
    tok_out.hit_src <= tok_in.hit ? tok_in.hit_src : src;
    free_out        <= free_in || !valid;
    free_idx_out    <= free_in ? free_idx_in : MY_IDX;
  end

endmodule
